FILE: sv/fcp_pkg.sv
// Package for the frontier colour placer: sizes, payload types, neighbour offsets.
// Used by fcp_ctrl, fcp_datapath and the top level; depends on nothing.
package fcp_pkg;

    localparam int MaxSide   = 128;
    localparam int SideBits  = $clog2(MaxSide);
    localparam int NumCells  = MaxSide * MaxSide;
    localparam int CellBits  = $clog2(NumCells);
    localparam int LenBits   = CellBits + 1;
    localparam int ColBits   = 24;
    localparam int DistBits  = 18;
    localparam int CfgBits   = 8;
    localparam int NbrCount  = 8;

    // Configuration register indexes.
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [6:0]          place_x;
        logic [6:0]          place_y;
        logic [DistBits-1:0] best_distance;
        logic                grid_full;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;      // clear one entry of the maps
        logic load_item;     // capture the input colour
        logic first_place;   // choose the centre cell
        logic scan_init;     // reset scan pointer and best value
        logic scan_read;     // issue read of frontier entry
        logic nbr_read;      // issue read of neighbour k
        logic nbr_eval;      // compare neighbour k result
        logic take_best;     // read chosen entry
        logic shift_step;    // move one frontier entry down
        logic commit;        // write colour and filled bit
        logic add_step;      // visit neighbour k for append
        logic emit;          // present result
        logic emit_full;     // present grid-full result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic first_empty;   // nothing placed yet
        logic list_empty;
        logic scan_last;     // pointer at last entry
        logic nbr_last;      // k == 7; when appending, only on the write phase
        logic shift_done;
    } stat_t;

    function automatic logic signed [1:0] nbr_dx(input logic [2:0] k);
        case (k)
            3'd0, 3'd3, 3'd5: nbr_dx = -2'sd1;
            3'd1, 3'd6:       nbr_dx = 2'sd0;
            default:          nbr_dx = 2'sd1;
        endcase
    endfunction

    function automatic logic signed [1:0] nbr_dy(input logic [2:0] k);
        case (k)
            3'd0, 3'd1, 3'd2: nbr_dy = -2'sd1;
            3'd3, 3'd4:       nbr_dy = 2'sd0;
            default:          nbr_dy = 2'sd1;
        endcase
    endfunction

endpackage

FILE: sv/fcp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module fcp_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/fcp_ctrl.sv
// Controller state machine of the frontier colour placer.
// Depends on fcp_pkg; drives the datapath through fcp_pkg::cmd_t.
module fcp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  fcp_pkg::stat_t stat,
    output fcp_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DECIDE= 4'd2;
    localparam logic [3:0] S_SREAD = 4'd3;
    localparam logic [3:0] S_NREAD = 4'd4;
    localparam logic [3:0] S_NWAIT = 4'd5;
    localparam logic [3:0] S_NEVAL = 4'd6;
    localparam logic [3:0] S_TAKE  = 4'd7;
    localparam logic [3:0] S_SHIFT = 4'd9;
    localparam logic [3:0] S_COMMIT= 4'd10;
    localparam logic [3:0] S_ADD   = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;
    localparam logic [3:0] S_FULL  = 4'd13;
    localparam logic [3:0] S_AWAIT = 4'd14;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.first_empty)
                begin
                    cmd.first_place = 1'b1;
                    state_next      = S_COMMIT;
                end
                else if (stat.list_empty)
                begin
                    state_next = S_FULL;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SREAD;
                end
            end
            S_SREAD:
            begin
                cmd.scan_read = 1'b1;
                state_next    = S_NREAD;
            end
            S_NREAD:
            begin
                // Entry data is registered; this state captures it before neighbour reads.
                state_next = S_NWAIT;
            end
            S_NWAIT:
            begin
                cmd.nbr_read = 1'b1;
                state_next   = S_NEVAL;
            end
            S_NEVAL:
            begin
                state_next = S_AWAIT;
            end
            S_AWAIT:
            begin
                cmd.nbr_eval = 1'b1;
                if (!stat.nbr_last)
                begin
                    state_next = S_NWAIT;
                end
                else if (!stat.scan_last)
                begin
                    state_next = S_SREAD;
                end
                else
                begin
                    state_next = S_TAKE;
                end
            end
            S_TAKE:
            begin
                // The chosen entry arrives in the first shift cycle.
                cmd.take_best = 1'b1;
                state_next    = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add_step = 1'b1;
                if (stat.nbr_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            S_FULL:
            begin
                cmd.emit_full = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

FILE: sv/fcp_datapath.sv
// Datapath of the frontier colour placer: maps, frontier list, distance unit.
// Depends on fcp_pkg and fcp_ram; commanded by fcp_ctrl.
module fcp_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fcp_pkg::in_item_t             item,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [fcp_pkg::CfgBits-1:0]   cfg_data,
    input  fcp_pkg::cmd_t                 cmd,
    output fcp_pkg::stat_t                stat,
    output logic                          res_valid,
    output fcp_pkg::out_item_t            res
);

    localparam int CB = fcp_pkg::CellBits;
    localparam int LB = fcp_pkg::LenBits;
    localparam int SB = fcp_pkg::SideBits;

    // Configuration registers, saturated when used.
    logic [fcp_pkg::CfgBits-1:0] width_reg, height_reg;
    logic [SB:0] w_sat, h_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= fcp_pkg::CfgBits'(fcp_pkg::MaxSide);
            height_reg <= fcp_pkg::CfgBits'(fcp_pkg::MaxSide);
        end
        else if (cfg_we)
        begin
            if (cfg_index == fcp_pkg::CFG_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else
            begin
                height_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            w_sat = (SB+1)'(1);
        else if (width_reg > fcp_pkg::CfgBits'(fcp_pkg::MaxSide))
            w_sat = (SB+1)'(fcp_pkg::MaxSide);
        else
            w_sat = (SB+1)'(width_reg);
        if (height_reg == '0)
            h_sat = (SB+1)'(1);
        else if (height_reg > fcp_pkg::CfgBits'(fcp_pkg::MaxSide))
            h_sat = (SB+1)'(fcp_pkg::MaxSide);
        else
            h_sat = (SB+1)'(height_reg);
    end

    // Control registers.
    logic [CB:0]   clr_reg;
    logic [LB-1:0] len_reg, ptr_reg, best_pos_reg, sh_reg;
    logic          placed_reg, found_reg;
    logic [17:0]   best_reg;
    logic [2:0]    k_reg;
    logic [CB-1:0] cell_reg, entry_reg;
    fcp_pkg::in_item_t item_reg;
    logic          nbr_ok_reg;

    // Flag maps: bit 0 filled, bit 1 on frontier.
    logic          flag_we;
    logic [CB-1:0] flag_waddr, flag_raddr;
    logic [1:0]    flag_wdata, flag_rdata;
    // Colour memory.
    logic          col_we;
    logic [CB-1:0] col_raddr;
    logic [23:0]   col_rdata;
    // Frontier list memory.
    logic          lst_we;
    logic [CB-1:0] lst_waddr, lst_raddr, lst_rdata;
    logic [CB-1:0] lst_wdata;

    fcp_ram #(.Width(2), .Depth(fcp_pkg::NumCells)) u_flags (
        .clk(clk), .we(flag_we), .waddr(flag_waddr), .wdata(flag_wdata),
        .raddr(flag_raddr), .rdata(flag_rdata));
    fcp_ram #(.Width(fcp_pkg::ColBits), .Depth(fcp_pkg::NumCells)) u_colour (
        .clk(clk), .we(col_we), .waddr(cell_reg), .wdata(item_reg),
        .raddr(col_raddr), .rdata(col_rdata));
    fcp_ram #(.Width(CB), .Depth(fcp_pkg::NumCells)) u_list (
        .clk(clk), .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
        .raddr(lst_raddr), .rdata(lst_rdata));

    // Neighbour coordinates of a base cell for offset k.
    logic [CB-1:0]     base_cell;
    logic signed [1:0] off_x, off_y;
    logic [SB:0]       nx, ny;
    logic              n_in;
    logic [CB-1:0]     n_idx;

    assign base_cell = cmd.add_step ? cell_reg : entry_reg;
    assign off_x     = fcp_pkg::nbr_dx(k_reg);
    assign off_y     = fcp_pkg::nbr_dy(k_reg);

    always_comb
    begin
        nx   = {1'b0, base_cell[SB-1:0]} + {{(SB-1){off_x[1]}}, off_x};
        ny   = {1'b0, base_cell[CB-1:SB]} + {{(SB-1){off_y[1]}}, off_y};
        // Negative wraps above MaxSide, so one compare covers both ends.
        n_in = (nx < w_sat) && (ny < h_sat);
        n_idx = {ny[SB-1:0], nx[SB-1:0]};
    end

    // Append visit reads the flags of each neighbour, then writes them.
    logic add_phase_reg;
    logic [CB-1:0] add_idx_reg;
    logic add_in_reg;

    // Distance from the registered neighbour colour.
    logic signed [8:0] dr, dg, db;
    logic [17:0] nbr_dist;
    assign dr = $signed({1'b0, col_rdata[23:16]}) - $signed({1'b0, item_reg.red});
    assign dg = $signed({1'b0, col_rdata[15:8]}) - $signed({1'b0, item_reg.green});
    assign db = $signed({1'b0, col_rdata[7:0]}) - $signed({1'b0, item_reg.blue});
    assign nbr_dist = 18'(dr * dr) + 18'(dg * dg) + 18'(db * db);

    // Memory port steering.
    always_comb
    begin
        flag_we    = 1'b0;
        flag_waddr = cell_reg;
        flag_wdata = 2'b01;
        flag_raddr = n_idx;
        col_we     = cmd.commit;
        col_raddr  = n_idx;
        lst_we     = 1'b0;
        lst_waddr  = sh_reg[CB-1:0];
        lst_wdata  = lst_rdata;
        lst_raddr  = ptr_reg[CB-1:0];
        if (cmd.clr_step)
        begin
            flag_we    = 1'b1;
            flag_waddr = clr_reg[CB-1:0];
            flag_wdata = 2'b00;
        end
        else if (cmd.commit)
        begin
            flag_we = 1'b1;
        end
        else if (cmd.add_step && add_phase_reg)
        begin
            flag_waddr = add_idx_reg;
            flag_wdata = 2'b10;
            if (add_in_reg && flag_rdata == 2'b00 && len_reg < LB'(fcp_pkg::NumCells))
            begin
                flag_we   = 1'b1;
                lst_we    = 1'b1;
                lst_waddr = len_reg[CB-1:0];
                lst_wdata = add_idx_reg;
            end
        end
        if (cmd.take_best)
        begin
            lst_raddr = best_pos_reg[CB-1:0];
        end
        else if (cmd.shift_step)
        begin
            lst_raddr = CB'(sh_reg + LB'(1));
            // Entry at sh was read last cycle; write it down one place.
            lst_we    = (sh_reg != best_pos_reg);
            lst_waddr = CB'(sh_reg - LB'(1));
        end
    end

    assign stat.clr_done    = clr_reg[CB];
    assign stat.first_empty = !placed_reg;
    assign stat.list_empty  = (len_reg == '0);
    assign stat.scan_last   = (ptr_reg == len_reg - LB'(1));
    assign stat.nbr_last    = (k_reg == 3'd7) && (!cmd.add_step || add_phase_reg);
    assign stat.shift_done  = (sh_reg >= len_reg);

    // Sequential datapath state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            len_reg       <= '0;
            placed_reg    <= 1'b0;
            ptr_reg       <= '0;
            k_reg         <= '0;
            found_reg     <= 1'b0;
            add_phase_reg <= 1'b0;
            res_valid     <= 1'b0;
        end
        else
        begin
            res_valid <= cmd.emit || cmd.emit_full;
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + (CB+1)'(1);
            end
            if (cmd.load_item)
            begin
                item_reg <= item;
            end
            if (cmd.first_place)
            begin
                cell_reg <= {h_sat[SB:1], w_sat[SB:1]};
                best_reg <= '0;
            end
            if (cmd.scan_init)
            begin
                ptr_reg   <= '0;
                found_reg <= 1'b0;
                best_reg  <= '0;
                best_pos_reg <= '0;
            end
            if (cmd.scan_read)
            begin
                k_reg <= '0;
            end
            if (cmd.nbr_read)
            begin
                nbr_ok_reg <= n_in;
            end
            // Entry data arrives in the cycle after scan_read.
            if (!cmd.scan_read && !cmd.nbr_read && !cmd.nbr_eval && !cmd.add_step
                && !cmd.shift_step && !cmd.take_best && !cmd.commit)
            begin
                entry_reg <= lst_rdata;
            end
            if (cmd.nbr_eval)
            begin
                if (nbr_ok_reg && flag_rdata[0] && (!found_reg || nbr_dist < best_reg))
                begin
                    found_reg    <= 1'b1;
                    best_reg     <= nbr_dist;
                    best_pos_reg <= ptr_reg;
                end
                k_reg <= k_reg + 3'd1;
                if (k_reg == 3'd7)
                begin
                    ptr_reg <= ptr_reg + LB'(1);
                end
            end
            if (cmd.take_best)
            begin
                sh_reg <= best_pos_reg;
            end
            if (cmd.shift_step)
            begin
                if (sh_reg == best_pos_reg)
                begin
                    cell_reg <= lst_rdata;
                end
                sh_reg <= sh_reg + LB'(1);
                // The list loses one entry, once per shift pass.
                if (sh_reg + LB'(1) == len_reg)
                begin
                    len_reg <= len_reg - LB'(1);
                end
            end
            if (cmd.commit)
            begin
                placed_reg    <= 1'b1;
                k_reg         <= '0;
                add_phase_reg <= 1'b0;
            end
            if (cmd.add_step)
            begin
                add_phase_reg <= !add_phase_reg;
                if (!add_phase_reg)
                begin
                    add_idx_reg <= n_idx;
                    add_in_reg  <= n_in;
                end
                else
                begin
                    k_reg <= k_reg + 3'd1;
                    if (lst_we)
                    begin
                        len_reg <= len_reg + LB'(1);
                    end
                end
            end
            if (cmd.emit)
            begin
                res.place_x       <= 7'(cell_reg[SB-1:0]);
                res.place_y       <= 7'(cell_reg[CB-1:SB]);
                res.best_distance <= best_reg;
                res.grid_full     <= 1'b0;
            end
            if (cmd.emit_full)
            begin
                res <= '{grid_full: 1'b1, default: '0};
            end
        end
    end

endmodule

FILE: sv/frontier_colour_placer.sv
// Top level of the frontier colour placer: controller plus datapath.
// Depends on fcp_pkg, fcp_ctrl, fcp_datapath.
//
//  channel   signals                         transfer when
//  input     start, busy, colour             start high and busy low
//  result    done, placement                 done high (one cycle, no stall)
//  config    cfg_we, cfg_index, cfg_data     cfg_we high
//
// After reset the maps are cleared with busy high.
// For a frontier of L entries, every entry is read and then each of its eight
// neighbours through the single flag and colour read ports, then the list is
// compacted one entry a cycle. The first placement and a dropped colour skip the
// scan. The result strobe follows in the first idle cycle; results cannot stall.
module frontier_colour_placer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  fcp_pkg::in_item_t           colour,
    output logic                        done,
    output fcp_pkg::out_item_t          placement,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [fcp_pkg::CfgBits-1:0] cfg_data
);

    fcp_pkg::cmd_t  cmd;
    fcp_pkg::stat_t stat;

    fcp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .stat(stat), .cmd(cmd));

    fcp_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .item(colour), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .stat(stat),
        .res_valid(done), .res(placement));

endmodule

FILE: test/tb_top.sv
// Testbench for frontier_colour_placer: drives colours and grid sizes, predicts every placement.
// Depends on fcp_pkg and the frontier_colour_placer RTL.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 10000000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    fcp_pkg::in_item_t  colour = '0;
    logic               done;
    fcp_pkg::out_item_t placement;
    logic               cfg_we = 1'b0;
    logic               cfg_index = fcp_pkg::CFG_WIDTH;
    logic [fcp_pkg::CfgBits-1:0] cfg_data = '0;

    // Predictor state: the canvas as the block should hold it.
    logic [fcp_pkg::ColBits-1:0] canvas_colour [fcp_pkg::NumCells];
    bit                 canvas_filled [fcp_pkg::NumCells];
    bit                 on_frontier [fcp_pkg::NumCells];
    int                 frontier_cells [$];
    int                 placements = 0;
    int                 canvas_w = fcp_pkg::MaxSide;
    int                 canvas_h = fcp_pkg::MaxSide;

    fcp_pkg::out_item_t placement_queue [$];
    int                 mismatches = 0;
    int                 cycles = 0;
    fcp_pkg::in_item_t  last_colour = '0;

    frontier_colour_placer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .colour    (colour),
        .done      (done),
        .placement (placement),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int saturate_side(input logic [fcp_pkg::CfgBits-1:0] v);
        if (v == 0)
            return 1;
        if (v > fcp_pkg::MaxSide)
            return fcp_pkg::MaxSide;
        return int'(v);
    endfunction

    function automatic int sq_distance(input logic [fcp_pkg::ColBits-1:0] c,
                                       input fcp_pkg::in_item_t col);
        int dr;
        int dg;
        int db;
        dr = int'(c[23:16]) - int'(col.red);
        dg = int'(c[15:8]) - int'(col.green);
        db = int'(c[7:0]) - int'(col.blue);
        return dr * dr + dg * dg + db * db;
    endfunction

    function automatic bit in_canvas(input int x, input int y);
        return x >= 0 && x < canvas_w && y >= 0 && y < canvas_h;
    endfunction

    // Works out where one colour lands and updates the predicted canvas.
    function automatic fcp_pkg::out_item_t place_colour(input fcp_pkg::in_item_t col);
        fcp_pkg::out_item_t res;
        int x;
        int y;
        int cell_idx;
        int best;
        int best_pos;
        int d;
        int nx;
        int ny;
        bit found;
        res = '0;
        best = 0;
        best_pos = 0;
        found = 1'b0;
        if (placements == 0)
        begin
            x = canvas_w / 2;
            y = canvas_h / 2;
            cell_idx = y * fcp_pkg::MaxSide + x;
        end
        else if (frontier_cells.size() == 0)
        begin
            res.grid_full = 1'b1;
            return res;
        end
        else
        begin
            // Scan the frontier in order; strictly smaller distance wins.
            foreach (frontier_cells[p])
            begin
                for (int k = 0; k < fcp_pkg::NbrCount; k++)
                begin
                    nx = frontier_cells[p] % fcp_pkg::MaxSide
                         + int'(fcp_pkg::nbr_dx(k[2:0]));
                    ny = frontier_cells[p] / fcp_pkg::MaxSide
                         + int'(fcp_pkg::nbr_dy(k[2:0]));
                    if (!in_canvas(nx, ny))
                        continue;
                    if (!canvas_filled[ny * fcp_pkg::MaxSide + nx])
                        continue;
                    d = sq_distance(canvas_colour[ny * fcp_pkg::MaxSide + nx], col);
                    if (!found || d < best)
                    begin
                        found = 1'b1;
                        best = d;
                        best_pos = p;
                    end
                end
            end
            cell_idx = frontier_cells[best_pos];
            frontier_cells.delete(best_pos);
            on_frontier[cell_idx] = 1'b0;
            x = cell_idx % fcp_pkg::MaxSide;
            y = cell_idx / fcp_pkg::MaxSide;
        end
        canvas_colour[cell_idx] = col;
        canvas_filled[cell_idx] = 1'b1;
        placements++;
        // Append empty neighbours in raster order.
        for (int k = 0; k < fcp_pkg::NbrCount; k++)
        begin
            nx = x + int'(fcp_pkg::nbr_dx(k[2:0]));
            ny = y + int'(fcp_pkg::nbr_dy(k[2:0]));
            if (!in_canvas(nx, ny))
                continue;
            if (canvas_filled[ny * fcp_pkg::MaxSide + nx]
                || on_frontier[ny * fcp_pkg::MaxSide + nx])
                continue;
            frontier_cells.insert(frontier_cells.size(), ny * fcp_pkg::MaxSide + nx);
            on_frontier[ny * fcp_pkg::MaxSide + nx] = 1'b1;
        end
        res.place_x = x[6:0];
        res.place_y = y[6:0];
        res.best_distance = best[fcp_pkg::DistBits-1:0];
        return res;
    endfunction

    // Sends one colour; start stays high when the next transfer follows at once.
    task automatic send_colour(input fcp_pkg::in_item_t col);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        colour <= col;
        do
            @(posedge clk);
        while (busy);
        placement_queue.insert(placement_queue.size(), place_colour(col));
        last_colour = col;
    endtask

    task automatic send_random(input int count);
        fcp_pkg::in_item_t col;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                col = last_colour;
            else
                col = fcp_pkg::in_item_t'(24'($urandom_range(0, 24'hFFFFFF)));
            send_colour(col);
        end
    endtask

    // Lets the block drain completely before a register write.
    task automatic wait_idle;
        start <= 1'b0;
        while (placement_queue.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic set_canvas(input logic [fcp_pkg::CfgBits-1:0] w,
                              input logic [fcp_pkg::CfgBits-1:0] h);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= fcp_pkg::CFG_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= fcp_pkg::CFG_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        canvas_w = saturate_side(w);
        canvas_h = saturate_side(h);
    endtask

    // Result checker: each strobe is compared with the oldest prediction.
    always @(posedge clk)
    begin
        fcp_pkg::out_item_t want;
        if (rst_n && done)
        begin
            if (placement_queue.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, placement);
                mismatches++;
            end
            else
            begin
                want = placement_queue.pop_front();
                if (placement.place_x !== want.place_x)
                begin
                    $display("%0t: place_x expected %0d actual %0d",
                             $time, want.place_x, placement.place_x);
                    mismatches++;
                end
                if (placement.place_y !== want.place_y)
                begin
                    $display("%0t: place_y expected %0d actual %0d",
                             $time, want.place_y, placement.place_y);
                    mismatches++;
                end
                if (placement.best_distance !== want.best_distance)
                begin
                    $display("%0t: best_distance expected %0d actual %0d",
                             $time, want.best_distance, placement.best_distance);
                    mismatches++;
                end
                if (placement.grid_full !== want.grid_full)
                begin
                    $display("%0t: grid_full expected %0d actual %0d",
                             $time, want.grid_full, placement.grid_full);
                    mismatches++;
                end
            end
        end
    end

    // First placement on a one-column canvas with saturated sizes, extreme colours.
    task automatic test_first_placement;
        set_canvas(8'd0, 8'd200);
        send_colour('{8'h00, 8'h00, 8'h00});
        send_colour('{8'hFF, 8'hFF, 8'hFF});
        send_colour('{8'hFF, 8'h00, 8'h00});
        send_colour('{8'h00, 8'hFF, 8'h00});
        send_colour('{8'h00, 8'h00, 8'hFF});
        send_colour('{8'hAA, 8'h55, 8'hAA});
        send_colour('{8'h55, 8'hAA, 8'h55});
    endtask

    // Equal distances: the earliest frontier entry must win.
    task automatic test_ties;
        set_canvas(8'd3, 8'd255);
        for (int i = 0; i < 6; i++)
            send_colour('{8'h80, 8'h80, 8'h80});
        send_colour('{8'h7F, 8'h80, 8'h81});
        send_colour('{8'h81, 8'h80, 8'h7F});
    endtask

    // Canvas shrunk away from the blob: no frontier cell has a filled neighbour.
    task automatic test_no_neighbour;
        set_canvas(8'd3, 8'd1);
        send_random(3);
        set_canvas(8'd3, 8'd128);
        send_random(3);
    endtask

    task automatic test_random_strips;
        set_canvas(8'd4, 8'd128);
        send_random(220);
        set_canvas(8'd8, 8'd128);
        send_random(190);
    endtask

    task automatic test_full_canvas;
        set_canvas(8'd128, 8'd128);
        send_random(30);
    endtask

    // One-cell canvas: the frontier drains, then every colour is dropped.
    task automatic test_grid_full;
        set_canvas(8'd1, 8'd1);
        while (frontier_cells.size() != 0)
            send_random(1);
        send_random(6);
        set_canvas(8'd255, 8'd0);
        send_random(3);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_first_placement();
        test_ties();
        test_no_neighbour();
        test_random_strips();
        test_full_canvas();
        test_grid_full();
        wait_idle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
